// File: src/ptd_pkg.sv
// Package: shared types, constants and codes of the periodic task dispatcher.
`timescale 1ns / 1ps
`default_nettype none
package ptd_pkg;

  localparam int MAX_TASKS = 8;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int SLOT_W    = 4;
  localparam int CMP_W     = ((CNT_W > SLOT_W) ? CNT_W : SLOT_W) + 1;
  localparam int PERIOD_W  = 32;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_CREATE = 2'd1,
    OP_DELETE = 2'd2
  } ptd_op_t;

  typedef enum logic [1:0] {
    KIND_DISPATCH = 2'd0,
    KIND_IDLE     = 2'd1,
    KIND_STATUS   = 2'd2
  } ptd_kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_BAD_SLOT = 2'd2
  } ptd_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } ptd_state_t;

  typedef struct packed {
    logic [1:0]          operation;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period;
    logic                one_shot;
  } ptd_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] task_id;
    logic [1:0] status;
    logic       last;
  } ptd_out_t;

  // Command from the controller to one cell.
  typedef struct packed {
    logic                wr;
    logic                del;
    logic [PERIOD_W-1:0] period;
    logic                one_shot;
  } ptd_cmd_t;

  // Report from one cell to the controller.
  typedef struct packed {
    logic valid;
    logic hit;
    logic drop;
  } ptd_rsp_t;

endpackage
`default_nettype wire

// File: src/periodic_task_dispatcher.sv
// Top level: command decode, scan sequencer and result register of the dispatcher.
`timescale 1ns / 1ps
`default_nettype none
// Periodic task dispatcher.
// Input channel: a command beat (in_data) is taken at a rising edge where start
// is high and busy is low. Operation create or delete answers with one status
// beat, on out_valid/out_data in the cycle after the command was taken; busy
// stays low, so a command may follow in every cycle.
// Operation tick sends a scan token down the row of slot cells, one cell per
// cycle, slot 0 first. Each due task gives one dispatch beat in slot order.
// The dispatch found is held back one step so that the final one can carry
// last; a drain cycle after the row releases it, or an idle beat if no task
// was due. A tick therefore keeps busy high while the token walks through
// the cells and while the drain state lasts, and its beats appear after
// acceptance, up to the cycle after the drain. Operation code 3 is taken
// and dropped with no beat. Every result beat is shown for exactly one
// cycle; the receiver cannot stall, so no beat waits. Reset (rst_n low,
// synchronous) empties all slots, clears the task count and returns the
// sequencer to idle.
module periodic_task_dispatcher (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  ptd_pkg::ptd_in_t  in_data,
  output logic              out_valid,
  output ptd_pkg::ptd_out_t out_data
);
  import ptd_pkg::*;

  ptd_state_t           state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 pend_r, pend_nxt;
  logic [IDX_W-1:0]     pend_id_r, pend_id_nxt;
  logic [CNT_W-1:0]     task_count_r, task_count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ptd_out_t             out_data_r, out_data_nxt;

  logic                 accept;
  logic                 tick_go;
  logic                 slot_bad;
  logic                 table_full;
  logic [IDX_W-1:0]     slot_idx;
  logic                 slot_used;
  logic                 do_wr;
  logic                 do_del;
  logic                 any_hit;
  logic                 any_drop;

  logic [MAX_TASKS-1:0] token;
  logic [MAX_TASKS-1:0] valid_vec;
  logic [MAX_TASKS-1:0] hit_vec;
  logic [MAX_TASKS-1:0] drop_vec;
  ptd_cmd_t             cmd   [MAX_TASKS];
  ptd_rsp_t             rsp   [MAX_TASKS];

  assign accept     = start && (state_r == ST_IDLE);
  assign slot_bad   = CMP_W'(in_data.slot) >= CMP_W'(MAX_TASKS);
  assign table_full = task_count_r >= CNT_W'(MAX_TASKS);
  assign slot_idx   = IDX_W'(in_data.slot);
  assign slot_used  = valid_vec[slot_idx];
  assign any_hit    = |hit_vec;
  assign any_drop   = |drop_vec;

  // Row of slot cells; the token enters at slot 0 and walks one cell a cycle.
  genvar g;
  generate
    for (g = 0; g < MAX_TASKS; g++) begin : g_cell
      logic tok_in;
      if (g == 0) begin : g_head
        assign tok_in = tick_go;
      end else begin : g_link
        assign tok_in = token[g-1];
      end

      assign cmd[g].wr       = do_wr && (slot_idx == IDX_W'(g));
      assign cmd[g].del      = do_del && (slot_idx == IDX_W'(g));
      assign cmd[g].period   = in_data.period;
      assign cmd[g].one_shot = in_data.one_shot;

      ptd_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .token_in  (tok_in),
        .token_out (token[g]),
        .cmd       (cmd[g]),
        .rsp       (rsp[g])
      );

      assign valid_vec[g] = rsp[g].valid;
      assign hit_vec[g]   = rsp[g].hit;
      assign drop_vec[g]  = rsp[g].drop;
    end
  endgenerate

  // Sequencer: decode commands, follow the token, hold back one dispatch.
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    pend_id_nxt    = pend_id_r;
    task_count_nxt = task_count_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    tick_go        = 1'b0;
    do_wr          = 1'b0;
    do_del         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.operation)
            OP_TICK: begin
              tick_go   = 1'b1;
              idx_nxt   = '0;
              pend_nxt  = 1'b0;
              state_nxt = ST_SCAN;
            end
            OP_CREATE: begin
              out_valid_nxt        = 1'b1;
              out_data_nxt.kind    = KIND_STATUS;
              out_data_nxt.task_id = '0;
              out_data_nxt.last    = 1'b1;
              if (table_full) begin
                out_data_nxt.status = STAT_FULL;
              end else if (slot_bad) begin
                out_data_nxt.status = STAT_BAD_SLOT;
              end else begin
                out_data_nxt.status = STAT_OK;
                do_wr               = 1'b1;
                if (!slot_used) begin
                  task_count_nxt = task_count_r + 1'b1;
                end
              end
            end
            OP_DELETE: begin
              out_valid_nxt        = 1'b1;
              out_data_nxt.kind    = KIND_STATUS;
              out_data_nxt.task_id = '0;
              out_data_nxt.last    = 1'b1;
              if (slot_bad) begin
                out_data_nxt.status = STAT_BAD_SLOT;
              end else begin
                out_data_nxt.status = STAT_OK;
                do_del              = 1'b1;
                if (slot_used) begin
                  task_count_nxt = task_count_r - 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Release the held dispatch once a later one is found.
        if (any_hit) begin
          if (pend_r) begin
            out_valid_nxt        = 1'b1;
            out_data_nxt.kind    = KIND_DISPATCH;
            out_data_nxt.task_id = 3'(pend_id_r);
            out_data_nxt.status  = STAT_OK;
            out_data_nxt.last    = 1'b0;
          end
          pend_nxt    = 1'b1;
          pend_id_nxt = idx_r;
        end
        if (any_drop) begin
          task_count_nxt = task_count_r - 1'b1;
        end
        if (idx_r == IDX_W'(MAX_TASKS - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        out_valid_nxt       = 1'b1;
        out_data_nxt.status = STAT_OK;
        out_data_nxt.last   = 1'b1;
        if (pend_r) begin
          out_data_nxt.kind    = KIND_DISPATCH;
          out_data_nxt.task_id = 3'(pend_id_r);
        end else begin
          out_data_nxt.kind    = KIND_IDLE;
          out_data_nxt.task_id = '0;
        end
        pend_nxt  = 1'b0;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      pend_r       <= 1'b0;
      task_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      pend_r       <= pend_nxt;
      task_count_r <= task_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers: hold without reset.
  always_ff @(posedge clk) begin
    pend_id_r  <= pend_id_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: src/ptd_cell.sv
// Task slot cell: holds one slot and passes the scan token to its neighbour.
`timescale 1ns / 1ps
`default_nettype none
module ptd_cell (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               token_in,
  output logic              token_out,
  input  ptd_pkg::ptd_cmd_t cmd,
  output ptd_pkg::ptd_rsp_t rsp
);
  import ptd_pkg::*;

  logic                token_r, token_nxt;
  logic                valid_r, valid_nxt;
  logic                one_shot_r, one_shot_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [PERIOD_W-1:0] counter_r, counter_nxt;
  logic                due;
  logic                visit;

  assign due   = counter_r >= period_r;
  assign visit = token_r && valid_r;

  always_comb begin
    token_nxt    = token_in;
    valid_nxt    = valid_r;
    one_shot_nxt = one_shot_r;
    period_nxt   = period_r;
    counter_nxt  = counter_r;
    if (cmd.wr) begin
      valid_nxt    = 1'b1;
      one_shot_nxt = cmd.one_shot;
      period_nxt   = cmd.period;
      counter_nxt  = '0;
    end else if (cmd.del) begin
      valid_nxt = 1'b0;
    end else if (visit) begin
      if (due) begin
        counter_nxt = '0;
        if (one_shot_r) begin
          valid_nxt = 1'b0;
        end
      end else begin
        counter_nxt = counter_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      token_r <= token_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    one_shot_r <= one_shot_nxt;
    period_r   <= period_nxt;
    counter_r  <= counter_nxt;
  end

  assign token_out = token_r;
  assign rsp.valid = valid_r;
  assign rsp.hit   = visit && due;
  assign rsp.drop  = visit && due && one_shot_r;

endmodule
`default_nettype wire
